// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the checker module tcl_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising aclk edge, off while aresetn is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same, but the property is stated as antecedent and next-cycle consequent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tcl_pkg.sv =====
// ----------------------------------------------------------------------------
// tcl_pkg
// Types, codes and constants of the tone curve / RGB565 pixel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcl_pkg;

    localparam int NUM_STAGES = 4;

    localparam logic       ACT_PIXEL = 1'b0;
    localparam logic       ACT_KNOT  = 1'b1;

    localparam logic [1:0] CH_RED    = 2'd0;
    localparam logic [1:0] CH_GREEN  = 2'd1;
    localparam logic [1:0] CH_BLUE   = 2'd2;

    // values below this pass through the curve unchanged
    localparam logic [7:0] LOW_LIMIT = 8'd15;

    typedef struct packed {
        logic [NUM_STAGES-1:0] stage_en;
        logic                  curve_enable;
    } tcl_ctrl_t;

    typedef struct packed {
        logic       we;
        logic [3:0] idx;
        logic [7:0] data;
    } knot_wr_t;

    // reset knot i = 16*i + 15
    function automatic logic [7:0] knot_default(input logic [3:0] idx);
        return {idx, 4'hf};
    endfunction

endpackage

// ===== design/tcl_chan.sv =====
// ----------------------------------------------------------------------------
// tcl_chan
// One colour channel: 16-knot store and four-stage interpolation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcl_chan (
    input  logic              aclk,
    input  logic              aresetn,
    input  tcl_pkg::tcl_ctrl_t ctrl,
    input  tcl_pkg::knot_wr_t  knot_wr,
    input  logic [7:0]        value_in,
    output logic [7:0]        value_out
);
    import tcl_pkg::*;

    logic [7:0]  knot_mem [16];
    logic [15:0] knot_vld_reg;

    logic [7:0]  v_off;
    logic [3:0]  addr_a;
    logic [3:0]  addr_b;

    // stage 1
    logic [7:0]  a1_reg, b1_reg, v1_reg;
    logic [3:0]  f1_reg;
    logic        low1_reg;
    // stage 2
    logic [7:0]  a2_reg, diff2_reg, v2_reg;
    logic [3:0]  f2_reg;
    logic        low2_reg, down2_reg;
    // stage 3
    logic [7:0]  a3_reg, mag3_reg, v3_reg;
    logic        low3_reg, down3_reg;
    logic [11:0] prod3_next;
    // stage 4
    logic [7:0]  res_reg, res_next;

    assign v_off  = value_in - LOW_LIMIT;
    assign addr_a = v_off[7:4];
    assign addr_b = v_off[7:4] + 4'd1;

    always_ff @(posedge aclk) begin
        if (knot_wr.we) begin
            knot_mem[knot_wr.idx] <= knot_wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knot_vld_reg <= '0;
        end else if (knot_wr.we) begin
            knot_vld_reg[knot_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.stage_en[0]) begin
            a1_reg   <= knot_vld_reg[addr_a] ? knot_mem[addr_a] : knot_default(addr_a);
            b1_reg   <= knot_vld_reg[addr_b] ? knot_mem[addr_b] : knot_default(addr_b);
            f1_reg   <= v_off[3:0];
            v1_reg   <= value_in;
            low1_reg <= (value_in < LOW_LIMIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.stage_en[1]) begin
            a2_reg    <= a1_reg;
            down2_reg <= (b1_reg < a1_reg);
            diff2_reg <= (b1_reg < a1_reg) ? (a1_reg - b1_reg) : (b1_reg - a1_reg);
            f2_reg    <= f1_reg;
            v2_reg    <= v1_reg;
            low2_reg  <= low1_reg;
        end
    end

    assign prod3_next = diff2_reg * f2_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.stage_en[2]) begin
            a3_reg    <= a2_reg;
            mag3_reg  <= prod3_next[11:4];
            down3_reg <= down2_reg;
            v3_reg    <= v2_reg;
            low3_reg  <= low2_reg;
        end
    end

    always_comb begin
        if (!ctrl.curve_enable || low3_reg) begin
            res_next = v3_reg;
        end else if (down3_reg) begin
            res_next = a3_reg - mag3_reg;
        end else begin
            res_next = a3_reg + mag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.stage_en[3]) begin
            res_reg <= res_next;
        end
    end

    assign value_out = res_reg;

endmodule

// ===== design/tone_curve_lut_rgb565.sv =====
// ----------------------------------------------------------------------------
// tone_curve_lut_rgb565
// Per-channel piecewise-linear tone curve followed by an RGB888 to RGB565 pack.
// ----------------------------------------------------------------------------
// Input channel (s_*): each transfer is either a pixel (s_action = pixel),
// carrying s_red/s_green/s_blue, or a knot write (s_action = knot) that sets
// knot s_knot_index of channel s_channel to s_knot_value. A knot write takes
// effect at its transfer and yields no result; channel 3 is ignored.
// Output channel (m_*): one m_pixel_565 transfer per pixel, in input order.
// Pipeline: a pixel passes through four registered stages (knot read,
// difference, multiply, add/pack), in which every stage has its own valid
// bit, and m_valid is the valid bit of the last stage; throughput is one
// item per cycle while m_ready stays high.
// cfg_we/cfg_wdata write curve_enable; write it only with the pipeline empty.
// Reset: curve_enable = 0, every knot i reads 16*i+15, pipeline empty.
// Stall: with m_ready low, bubbles collapse; s_ready drops once all four
// stages hold pixels, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tone_curve_lut_rgb565 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [1:0]  s_channel,
    input  logic [3:0]  s_knot_index,
    input  logic [7:0]  s_knot_value,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pixel_565
);
    import tcl_pkg::*;

    logic                  curve_enable_reg;
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] rdy;
    logic                  s_xfer;
    tcl_ctrl_t             ctrl;
    knot_wr_t              wr_r, wr_g, wr_b;
    logic [7:0]            red_map, green_map, blue_map;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            curve_enable_reg <= cfg_wdata;
        end
    end

    always_comb begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_ready = rdy[0];
    assign s_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid && (s_action == ACT_PIXEL);
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign ctrl.stage_en     = rdy;
    assign ctrl.curve_enable = curve_enable_reg;

    always_comb begin
        wr_r.we   = s_xfer && (s_action == ACT_KNOT) && (s_channel == CH_RED);
        wr_g.we   = s_xfer && (s_action == ACT_KNOT) && (s_channel == CH_GREEN);
        wr_b.we   = s_xfer && (s_action == ACT_KNOT) && (s_channel == CH_BLUE);
        wr_r.idx  = s_knot_index;
        wr_g.idx  = s_knot_index;
        wr_b.idx  = s_knot_index;
        wr_r.data = s_knot_value;
        wr_g.data = s_knot_value;
        wr_b.data = s_knot_value;
    end

    tcl_chan u_red (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .knot_wr   (wr_r),
        .value_in  (s_red),
        .value_out (red_map)
    );

    tcl_chan u_green (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .knot_wr   (wr_g),
        .value_in  (s_green),
        .value_out (green_map)
    );

    tcl_chan u_blue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .knot_wr   (wr_b),
        .value_in  (s_blue),
        .value_out (blue_map)
    );

    assign m_valid     = vld_reg[NUM_STAGES-1];
    assign m_pixel_565 = {red_map[7:3], green_map[7:2], blue_map[7:3]};

endmodule

// ===== design/tcl_checker.sv =====
// ----------------------------------------------------------------------------
// tcl_checker
// Port-level checks of tone_curve_lut_rgb565, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_pixel_565
);
    import tcl_pkg::*;

    // a stalled result transfer stays offered
    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "m_valid dropped while stalled")

    `ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_pixel_565),
                 "m_pixel_565 changed while stalled")

    // input back-pressure only when the output is full and stalled
    `ASSERT_CLK(a_ready_cause, !s_ready |-> (m_valid && !m_ready),
                "s_ready low without output stall")

    // with m_ready held high from its input transfer on, a pixel reaches the output
    `ASSERT_CLK(a_latency,
                (s_valid && s_ready && (s_action == ACT_PIXEL) && m_ready)
                ##1 m_ready ##1 m_ready ##1 m_ready |-> ##1 m_valid,
                "pixel did not reach output in four cycles")

endmodule

bind tone_curve_lut_rgb565 tcl_checker u_tcl_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_action    (s_action),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_pixel_565 (m_pixel_565)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tone_curve_lut_rgb565. Pixel and knot-write
// transfers go in with random gaps and receiver stalls. A scoreboard keeps
// its own knot store and curve enable, predicts each packed pixel, and
// compares it with the oldest pending one. Both curve settings are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import tcl_pkg::*;

    localparam logic [1:0] CH_NONE      = 2'd3;
    localparam int         RESET_CYCLES = 12;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         IDLE_LIMIT   = 1000;
    localparam int         NUM_PHASES   = 6;
    localparam int         PHASE_ITEMS  = 250;
    localparam int         MAX_REPORTS  = 40;

    class pixel_scoreboard;
        logic [7:0]  knots [3][16];
        logic        curve_en;
        logic [15:0] expected_pixels [$];
        int          errors;

        function new();
            for (int c = 0; c < 3; c++)
                for (int i = 0; i < 16; i++)
                    knots[c][i] = 8'(16 * i + 15);
            curve_en = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch: %s", what);
        endtask

        function logic [7:0] map_level(int ch, logic [7:0] v);
            int seg, frac, lo, hi;
            if (v < LOW_LIMIT)
                return v;
            if (v == 8'hff)
                return knots[ch][15];
            seg  = (int'(v) - 15) / 16;
            frac = (int'(v) - 15) % 16;
            lo   = knots[ch][seg];
            hi   = knots[ch][seg + 1];
            if (hi >= lo)
                return 8'(lo + (hi - lo) * frac / 16);
            return 8'(lo - (lo - hi) * frac / 16);
        endfunction

        function void note_input(logic action, logic [1:0] ch, logic [3:0] idx,
                                 logic [7:0] val, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b);
            logic [7:0] rm, gm, bm;
            if (action == ACT_KNOT) begin
                if (ch != CH_NONE)
                    knots[ch][idx] = val;
                return;
            end
            rm = curve_en ? map_level(CH_RED, r)   : r;
            gm = curve_en ? map_level(CH_GREEN, g) : g;
            bm = curve_en ? map_level(CH_BLUE, b)  : b;
            expected_pixels.push_back({rm[7:3], gm[7:2], bm[7:3]});
        endfunction

        task check_result(logic [15:0] pix);
            logic [15:0] want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("pixel_565 %h with nothing pending", pix));
                return;
            end
            want = expected_pixels.pop_front();
            if (pix !== want)
                report($sformatf("pixel_565 got %h want %h", pix, want));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic [1:0]  s_channel;
    logic [3:0]  s_knot_index;
    logic [7:0]  s_knot_value;
    logic [7:0]  s_red;
    logic [7:0]  s_green;
    logic [7:0]  s_blue;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_pixel_565;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    pixel_scoreboard sb = new();

    tone_curve_lut_rgb565 dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_channel    (s_channel),
        .s_knot_index (s_knot_index),
        .s_knot_value (s_knot_value),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_565  (m_pixel_565)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_level();
        if ($urandom_range(0, 9) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd14;
            2: return 8'd15;
            3: return 8'd16;
            4: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    task automatic send_item(input logic act, input logic [1:0] ch,
                             input logic [3:0] idx, input logic [7:0] val,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        s_valid      <= 1'b1;
        s_action     <= act;
        s_channel    <= ch;
        s_knot_index <= idx;
        s_knot_value <= val;
        s_red        <= r;
        s_green      <= g;
        s_blue       <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(act, ch, idx, val, r, g, b);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        send_item(ACT_PIXEL, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)), r, g, b);
        pause_sender(idle_len());
    endtask

    task automatic send_knot(input logic [1:0] ch, input logic [3:0] idx,
                             input logic [7:0] val);
        send_item(ACT_KNOT, ch, idx, val, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        pause_sender(idle_len());
    endtask

    task automatic send_random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            send_knot(CH_NONE, 4'($urandom_range(0, 15)), pick_level());
        else if (roll < 28)
            send_knot(2'($urandom_range(CH_RED, CH_BLUE)), 4'($urandom_range(0, 15)),
                      pick_level());
        else
            send_pixel(pick_level(), pick_level(), pick_level());
    endtask

    // knot writes leave nothing to wait on, so allow the pipeline to empty
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_curve_enable(input logic en);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.curve_en = en;
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_pixel_565);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int n;
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= 1'b0;
        s_valid      <= 1'b0;
        s_action     <= ACT_PIXEL;
        s_channel    <= CH_RED;
        s_knot_index <= 4'd0;
        s_knot_value <= 8'd0;
        s_red        <= 8'd0;
        s_green      <= 8'd0;
        s_blue       <= 8'd0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // raw pack
        write_curve_enable(1'b0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'haa, 8'h55, 8'h0f);
        wait_for_drain();

        // reset knots, then falling segments and end knots
        write_curve_enable(1'b1);
        send_pixel(8'd0, 8'd14, 8'd15);
        send_pixel(8'd16, 8'd254, 8'd255);
        send_pixel(8'd30, 8'd31, 8'd143);
        send_knot(CH_RED, 4'd0, 8'd255);
        send_knot(CH_RED, 4'd1, 8'd0);
        send_knot(CH_GREEN, 4'd15, 8'd0);
        send_knot(CH_BLUE, 4'd7, 8'd255);
        send_knot(CH_NONE, 4'd0, 8'd0);
        send_knot(CH_NONE, 4'd15, 8'd255);
        send_pixel(8'd20, 8'd255, 8'd120);
        send_pixel(8'd15, 8'd250, 8'd127);
        send_pixel(8'd29, 8'd240, 8'd135);
        wait_for_drain();

        write_curve_enable(1'b0);
        send_pixel(8'h80, 8'h40, 8'h20);
        send_pixel(8'h7f, 8'hbf, 8'hdf);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_for_drain();
            write_curve_enable((phase % 3) != 0);
            calm = (phase == 1 || phase == 4);
            if (phase == 1)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == 60)
                    calm = 1'b0;
                send_random_item();
            end
        end

        wait_for_drain();
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/tcl_pkg.sv
design/tcl_chan.sv
design/tone_curve_lut_rgb565.sv
design/tcl_checker.sv
test/testbench.sv
